FILE: rtl/core/sobel_edge_magnitude_top_assert.svh
// ----------------------------------------------------------------------------
// Sobel edge magnitude assertion macros
// Shared property macros. The including module must provide clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int unsigned PIX_W         = 8;
	localparam int unsigned CFG_W         = 16;
	localparam int unsigned CFG_WIDTH_W   = 11;
	localparam int unsigned ROW_W         = 16;
	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned WIDTH_RST     = 640;
	localparam int unsigned HEIGHT_RST    = 480;
	localparam int unsigned MIN_SIZE      = 3;
	localparam int unsigned SAT_MAX       = 255;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_FLUSH = 1'b1
	} req_type_t;

	// window[row][col]; row 0 is the oldest line, col 2 the newest pixel.
	typedef logic [2:0][2:0][PIX_W-1:0] window_t;

	typedef struct packed {
		logic valid;
		logic interior;
		logic last;
	} res_ctrl_t;

endpackage

FILE: rtl/core/sem_line_store.sv
// ----------------------------------------------------------------------------
// Sobel line store
// One row of pixels: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module sem_line_store #(
	parameter int unsigned DEPTH = sem_pkg::MAX_WIDTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [sem_pkg::PIX_W-1:0]  wdata,
	input  logic [AW-1:0]              raddr,
	output logic [sem_pkg::PIX_W-1:0]  rdata
);
	import sem_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/sem_out_stage.sv
// ----------------------------------------------------------------------------
// Sobel output stage
// Computes |gx|+|gy| from the window, saturates it, gives 0 at borders and holds the result.
// ----------------------------------------------------------------------------
module sem_out_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sem_pkg::res_ctrl_t         ctrl,
	input  sem_pkg::window_t           win,
	output logic                       load_ok,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,   // [7:0] edge_res
	output logic                       m_tlast    // frame_last
);
	import sem_pkg::*;

	logic             valid_q;
	logic [PIX_W-1:0] data_q;
	logic             last_q;

	logic [PIX_W+1:0] gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
	logic [PIX_W+2:0] mag_sum;
	logic [PIX_W-1:0] mag;

	// Kernel taps split into positive and negative halves, so the
	// absolute value is a compare and one subtract.
	always_comb begin
		gx_pos = (PIX_W+2)'(win[0][0]) + {1'b0, win[1][0], 1'b0} + (PIX_W+2)'(win[2][0]);
		gx_neg = (PIX_W+2)'(win[0][2]) + {1'b0, win[1][2], 1'b0} + (PIX_W+2)'(win[2][2]);
		gy_pos = (PIX_W+2)'(win[0][0]) + {1'b0, win[0][1], 1'b0} + (PIX_W+2)'(win[0][2]);
		gy_neg = (PIX_W+2)'(win[2][0]) + {1'b0, win[2][1], 1'b0} + (PIX_W+2)'(win[2][2]);
		gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
		gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
		mag_sum = (PIX_W+3)'(gx_abs) + (PIX_W+3)'(gy_abs);
		mag = (mag_sum > (PIX_W+3)'(SAT_MAX)) ? PIX_W'(SAT_MAX) : mag_sum[PIX_W-1:0];
	end

	assign load_ok = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && ctrl.valid) begin
			data_q <= ctrl.interior ? mag : '0;
			last_q <= ctrl.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

FILE: rtl/core/sobel_edge_magnitude_top.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude top level
// Streaming 3x3 Sobel |gx|+|gy| over a raster of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_ channel in raster order with s_tuser low. A result
// for position p leaves on the m_ channel once the pixel width+1 positions
// later has entered, so after the last pixel of a frame send width+1 items
// with s_tuser high; each of them releases one result, and the frame's final
// result carries m_tlast. Border rows and columns give 0.
// Throughput is one item per clock while the output is not stalled. An accepted
// item that releases a result passes the window and line stores first, then
// the magnitude and the output register, which drives m_tvalid.
// image_width (index 0) and image_height (index 1) are written through
// cfg_we/cfg_idx/cfg_wdata while the stream is idle; out-of-range values are
// clamped to the supported range.
// Reset clears the window, all position counters and the output valid flag;
// the line stores keep whatever they hold and are refilled by the frame.
// When m_tready stays low, one finished result waits in the output register
// and one more in the window stage; s_tready then drops until one moves.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top #(
	parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel
	input  logic                          s_tuser,   // req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] edge_res
	output logic                          m_tlast,   // frame_last
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [sem_pkg::CFG_W-1:0]     cfg_wdata
);
	import sem_pkg::*;

	`include "sobel_edge_magnitude_top_assert.svh"

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CMPW = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
	localparam int unsigned W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

	logic [WW-1:0]    width_q;
	logic [ROW_W-1:0] height_q;
	logic [CW-1:0]    in_col_q, out_col_q, in_col_nxt, rd_addr;
	logic [ROW_W-1:0] in_row_q, out_row_q;
	window_t          window_q;
	res_ctrl_t        ctrl_s1, ctrl_nxt;

	logic [CMPW-1:0]  cfg_w_ext;
	logic [WW-1:0]    cfg_w_clamp;
	logic [ROW_W-1:0] cfg_h_clamp;

	logic             accept, pix_acc, is_flush, emit, load_ok, s1_adv, ready_emit;
	logic [WW-1:0]    in_col_inc, out_col_inc;
	logic [ROW_W:0]   in_row_inc, out_row_inc, height_ext;
	logic             in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
	logic [PIX_W-1:0] top_rd, mid_rd;

	// Configuration: values are clamped at write time.
	always_comb begin
		cfg_w_ext = CMPW'(cfg_wdata[CFG_WIDTH_W-1:0]);
		if (cfg_w_ext < CMPW'(MIN_SIZE)) begin
			cfg_w_clamp = WW'(MIN_SIZE);
		end else if (cfg_w_ext > CMPW'(MAX_WIDTH)) begin
			cfg_w_clamp = WW'(MAX_WIDTH);
		end else begin
			cfg_w_clamp = cfg_w_ext[WW-1:0];
		end
		cfg_h_clamp = (cfg_wdata < CFG_W'(MIN_SIZE)) ? ROW_W'(MIN_SIZE) : cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RST);
			height_q <= ROW_W'(HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_IMAGE_WIDTH: width_q <= cfg_w_clamp;
				REG_IMAGE_HEIGHT: height_q <= cfg_h_clamp;
				default: ;
			endcase
		end
	end

	// Position tracking and handshake.
	always_comb begin
		s1_adv   = !ctrl_s1.valid || load_ok;
		s_tready = s1_adv;
		accept   = s_tvalid && s_tready;
		is_flush = (req_type_t'(s_tuser) == REQ_FLUSH);
		pix_acc  = accept && !is_flush;

		height_ext  = {1'b0, height_q};
		in_col_inc  = WW'(in_col_q) + 1'b1;
		in_row_inc  = {1'b0, in_row_q} + 1'b1;
		in_col_wrap = in_col_inc >= width_q;
		in_row_wrap = in_row_inc >= height_ext;
		in_col_nxt  = in_col_wrap ? '0 : in_col_inc[CW-1:0];

		// A pixel releases a result once the window has reached row 1, column 1.
		ready_emit = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
		emit       = accept && (is_flush || ready_emit);

		out_col_inc  = WW'(out_col_q) + 1'b1;
		out_row_inc  = {1'b0, out_row_q} + 1'b1;
		out_col_wrap = out_col_inc >= width_q;
		out_row_wrap = out_row_inc >= height_ext;

		ctrl_nxt.valid    = emit;
		ctrl_nxt.interior = (out_col_q != '0) && !out_col_wrap
			&& (out_row_q != '0) && !out_row_wrap;
		ctrl_nxt.last     = out_col_wrap && out_row_wrap;

		// The store output always shows the entry at the current input column.
		rd_addr = pix_acc ? in_col_nxt : in_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			window_q  <= '0;
			ctrl_s1   <= '0;
		end else begin
			if (pix_acc) begin
				in_col_q <= in_col_nxt;
				if (in_col_wrap) begin
					in_row_q <= in_row_wrap ? '0 : in_row_inc[ROW_W-1:0];
				end
				for (int r = 0; r < 3; r++) begin
					window_q[r][0] <= window_q[r][1];
					window_q[r][1] <= window_q[r][2];
				end
				window_q[0][2] <= top_rd;
				window_q[1][2] <= mid_rd;
				window_q[2][2] <= s_tdata;
			end
			if (emit) begin
				if (out_col_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_wrap ? '0 : out_row_inc[ROW_W-1:0];
				end else begin
					out_col_q <= out_col_inc[CW-1:0];
				end
			end
			if (s1_adv) begin
				ctrl_s1 <= ctrl_nxt;
			end
		end
	end

	sem_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_store_upper (
		.clk   (clk),
		.we    (pix_acc),
		.waddr (in_col_q),
		.wdata (mid_rd),
		.raddr (rd_addr),
		.rdata (top_rd)
	);

	sem_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_store_middle (
		.clk   (clk),
		.we    (pix_acc),
		.waddr (in_col_q),
		.wdata (s_tdata),
		.raddr (rd_addr),
		.rdata (mid_rd)
	);

	sem_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_s1),
		.win      (window_q),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`SEM_ASSERT_SAME(a_stall_only_when_full, !s_tready, ctrl_s1.valid,
		"input stalled with an empty window stage")
	`SEM_ASSERT_NEXT(a_flush_keeps_window, (accept && is_flush), $stable(window_q),
		"flush item changed the window")
	`SEM_ASSERT_NEXT(a_col_advance, (pix_acc && !in_col_wrap),
		(in_col_q == ($past(in_col_q) + 1'b1)), "input column did not advance")
	`SEM_ASSERT_SAME(a_last_wraps, (ctrl_s1.valid && ctrl_s1.last),
		((out_col_q == '0) && (out_row_q == '0)), "frame end without position wrap")

endmodule

FILE: sim/sobel_edge_magnitude_top_tb.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams gray pixel frames and flush requests into the block under random
// sender bursts and receiver stalls. A local copy of the line stores, the
// 3x3 window and the position counters predicts every result, and each
// output request is checked against the oldest prediction. Covers the reset
// frame size, the widest and tallest settings, clamped register values,
// mid-frame resizing and wrong flush counts.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sem_pkg::*;

	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned RANDOM_ITEMS = 150;

	typedef struct packed {
		logic [PIX_W-1:0] edge_res;
		logic             frame_last;
	} edge_result_t;

	typedef enum int {
		PIX_NOISE,
		PIX_EXTREME,
		PIX_SMOOTH
	} pixel_style_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = '0;
	logic             s_tuser   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic             cfg_we    = 1'b0;
	cfg_reg_t         cfg_idx   = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_wdata = '0;

	sobel_edge_magnitude_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Predicted state of the block.
	logic [CFG_WIDTH_W-1:0] width_reg  = CFG_WIDTH_W'(WIDTH_RST);
	logic [ROW_W-1:0]       height_reg = ROW_W'(HEIGHT_RST);
	logic [PIX_W-1:0]       upper_line [MAX_WIDTH_DEF] = '{default: '0};
	logic [PIX_W-1:0]       middle_line [MAX_WIDTH_DEF] = '{default: '0};
	logic [PIX_W-1:0]       win [3][3] = '{default: '0};
	int unsigned            in_col  = 0;
	int unsigned            in_row  = 0;
	int unsigned            out_col = 0;
	int unsigned            out_row = 0;

	edge_result_t expected_edges [$];
	int unsigned  mismatch_count = 0;
	int unsigned  requests_sent  = 0;
	int unsigned  burst_left     = 0;
	int unsigned  quiet_cycles   = 0;

	function automatic int unsigned eff_width();
		int unsigned w;
		w = width_reg;
		if (w < MIN_SIZE) w = MIN_SIZE;
		if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned h;
		h = height_reg;
		if (h < MIN_SIZE) h = MIN_SIZE;
		return h;
	endfunction

	function automatic logic [PIX_W-1:0] gradient_magnitude();
		int p [3][3];
		int gx, gy, sum;
		foreach (win[r, c]) p[r][c] = win[r][c];
		gx = p[0][0] + 2 * p[1][0] + p[2][0] - p[0][2] - 2 * p[1][2] - p[2][2];
		gy = p[0][0] + 2 * p[0][1] + p[0][2] - p[2][0] - 2 * p[2][1] - p[2][2];
		sum = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
		return (sum > SAT_MAX) ? PIX_W'(SAT_MAX) : PIX_W'(sum);
	endfunction

	// Result for the current output position, which then advances.
	function automatic edge_result_t next_edge_result();
		int unsigned w, h;
		edge_result_t r;
		w = eff_width();
		h = eff_height();
		r.edge_res = '0;
		r.frame_last = 1'b0;
		if (out_col >= 1 && out_col + 1 < w && out_row >= 1 && out_row + 1 < h)
			r.edge_res = gradient_magnitude();
		if (out_col + 1 >= w) begin
			out_col = 0;
			if (out_row + 1 >= h) begin
				out_row = 0;
				r.frame_last = 1'b1;
			end else begin
				out_row = (out_row + 1) & 16'hFFFF;
			end
		end else begin
			out_col++;
		end
		return r;
	endfunction

	function automatic void advance_sobel(req_type_t kind, logic [PIX_W-1:0] px);
		int unsigned idx;
		logic [PIX_W-1:0] top, mid;
		logic ready;
		if (kind == REQ_FLUSH) begin
			expected_edges.push_back(next_edge_result());
			return;
		end
		idx = (in_col < MAX_WIDTH_DEF) ? in_col : 0;
		top = upper_line[idx];
		mid = middle_line[idx];
		upper_line[idx] = mid;
		middle_line[idx] = px;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = px;
		// A result leaves once the window is a full row and one pixel ahead.
		ready = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		if (in_col + 1 >= eff_width()) begin
			in_col = 0;
			if (in_row + 1 >= eff_height())
				in_row = 0;
			else
				in_row = (in_row + 1) & 16'hFFFF;
		end else begin
			in_col++;
		end
		if (ready)
			expected_edges.push_back(next_edge_result());
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel(pixel_style_t style);
		case (style)
			PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			PIX_SMOOTH:  return PIX_W'($urandom_range(100, 130));
			default:     return PIX_W'($urandom);
		endcase
	endfunction

	task automatic send_request(req_type_t kind, logic [PIX_W-1:0] px);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= (kind == REQ_FLUSH) ? 8'($urandom) : px;
		do @(posedge clk); while (!s_tready);
		advance_sobel(kind, px);
		burst_left--;
		requests_sent++;
	endtask

	task automatic send_pixels(int unsigned count, pixel_style_t style);
		repeat (count) send_request(REQ_PIXEL, pick_pixel(style));
	endtask

	task automatic send_flushes(int unsigned count);
		repeat (count) send_request(REQ_FLUSH, 8'h00);
	endtask

	task automatic send_frame(pixel_style_t style);
		send_pixels(eff_width() * eff_height(), style);
		send_flushes(eff_width() + 1);
	endtask

	task automatic send_pattern(input logic [PIX_W-1:0] pat [9]);
		foreach (pat[i]) send_request(REQ_PIXEL, pat[i]);
		send_flushes(eff_width() + 1);
	endtask

	// Waits until every result is out, plus the pipeline depth for pixels
	// that release nothing.
	task automatic drain_pending();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_edges.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = value[CFG_WIDTH_W-1:0];
		else
			height_reg = value;
	endtask

	// Brings both position counters back to the start of a frame.
	task automatic realign_counters();
		while (in_col != 0 || in_row != 0) send_request(REQ_PIXEL, pick_pixel(PIX_NOISE));
		while (out_col != 0 || out_row != 0) send_flushes(1);
	endtask

	task automatic test_reset_size();
		// The reset width keeps all of these pixels in the first row, so no
		// result may leave yet.
		send_pixels(20, PIX_NOISE);
		drain_pending();
		// Column 20 lies past the new width and ends the row.
		write_reg(REG_IMAGE_WIDTH, 16'd4);
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		realign_counters();
		drain_pending();
	endtask

	task automatic test_widest_frame();
		// All ones clamps to the widest row, so these pixels stay in row 0.
		write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		send_pixels(30, PIX_SMOOTH);
		drain_pending();
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		realign_counters();
		drain_pending();
	endtask

	task automatic test_border_patterns();
		write_reg(REG_IMAGE_WIDTH, 16'd1);
		write_reg(REG_IMAGE_HEIGHT, 16'd0);
		send_pattern('{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00});
		send_pattern('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
		drain_pending();
		write_reg(REG_IMAGE_WIDTH, 16'd2);
		write_reg(REG_IMAGE_HEIGHT, 16'd2);
		send_pattern('{8'h00, 8'h00, 8'd40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		drain_pending();
	endtask

	task automatic test_tall_frame();
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
		send_pixels(12, PIX_NOISE);
		drain_pending();
		// The input row is now past the new height and counts as the last one.
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		realign_counters();
		drain_pending();
	endtask

	task automatic test_mid_frame_resize();
		write_reg(REG_IMAGE_WIDTH, 16'd8);
		write_reg(REG_IMAGE_HEIGHT, 16'd6);
		send_pixels(22, PIX_NOISE);
		drain_pending();
		write_reg(REG_IMAGE_WIDTH, 16'd4);
		send_pixels(10, PIX_SMOOTH);
		drain_pending();
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		realign_counters();
		send_frame(PIX_NOISE);
		drain_pending();
	endtask

	task automatic test_flush_count();
		write_reg(REG_IMAGE_WIDTH, 16'd5);
		write_reg(REG_IMAGE_HEIGHT, 16'd4);
		send_pixels(20, PIX_NOISE);
		send_flushes(2);
		send_frame(PIX_SMOOTH);
		realign_counters();
		send_pixels(20, PIX_NOISE);
		send_flushes(9);
		realign_counters();
		send_pixels(7, PIX_SMOOTH);
		send_flushes(1);
		send_pixels(13, PIX_SMOOTH);
		send_flushes(6);
		realign_counters();
		drain_pending();
	endtask

	task automatic write_random_size();
		int unsigned w, h;
		w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
		h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
		// Bits above the width register are ignored by the block.
		write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
		write_reg(REG_IMAGE_HEIGHT, 16'(h));
	endtask

	task automatic test_random_frames();
		int unsigned first, choice, area;
		pixel_style_t style;
		first = requests_sent;
		while (requests_sent - first < RANDOM_ITEMS) begin
			drain_pending();
			write_random_size();
			choice = $urandom_range(0, 9);
			style = pixel_style_t'($urandom_range(0, 2));
			area = eff_width() * eff_height();
			if (choice < 7) begin
				send_frame(style);
			end else if (choice == 7) begin
				send_pixels(area, style);
				send_flushes($urandom_range(0, 2 * eff_width() + 2));
				realign_counters();
			end else if (choice == 8) begin
				repeat (area) begin
					if ($urandom_range(0, 7) == 0) send_flushes(1);
					send_pixels(1, style);
				end
				send_flushes(eff_width() + 1);
				realign_counters();
			end else begin
				send_pixels($urandom_range(1, area - 1), style);
				drain_pending();
				write_random_size();
				send_pixels($urandom_range(0, 20), style);
				realign_counters();
			end
		end
		drain_pending();
	endtask

	always @(posedge clk) begin : check_results
		edge_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_edges.size() == 0) begin
				$error("unexpected result: edge_res %0d frame_last %0d", m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				exp_r = expected_edges.pop_front();
				if (m_tdata !== exp_r.edge_res) begin
					$error("edge_res expected %0d actual %0d", exp_r.edge_res, m_tdata);
					mismatch_count++;
				end
				if (m_tlast !== exp_r.frame_last) begin
					$error("frame_last expected %0d actual %0d", exp_r.frame_last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// The receiver switches between several stall patterns of random length.
	initial begin : rx_stalls
		int unsigned mode, span, hold, phase;
		hold = 0;
		phase = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(30, 200);
			repeat (span) begin
				@(negedge clk);
				phase++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ((phase % 7) >= 3);
					default: begin
						if (hold == 0 && $urandom_range(0, 15) == 0)
							hold = $urandom_range(4, 16);
						if (hold != 0) begin
							m_tready <= 1'b0;
							hold--;
						end else begin
							m_tready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("sobel_edge_magnitude_top_tb NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_size();
		test_widest_frame();
		test_border_patterns();
		test_tall_frame();
		test_mid_frame_resize();
		test_flush_count();
		test_random_frames();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_edges.size() == 0) begin
			$display("sobel_edge_magnitude_top_tb OK");
		end else begin
			$display("sobel_edge_magnitude_top_tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: sobel_edge_magnitude_top.f
+incdir+rtl/core
rtl/core/sem_pkg.sv
rtl/core/sem_line_store.sv
rtl/core/sem_out_stage.sv
rtl/core/sobel_edge_magnitude_top.sv
sim/sobel_edge_magnitude_top_tb.sv
